FILE: design/ctk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctk_pkg: shared types and constants of the command line tokenizer
// Character codes, phase encoding, result codes and the state and result
// records passed between the tokenizer modules.
// ----------------------------------------------------------------------------
package ctk_pkg;

	// Characters of the grammar
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DASH   = 8'h2d;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LOWA   = 8'h61;
	localparam logic [7:0] NUM_LETTERS = 8'd26;

	// Option index of the double dash, and mask width
	localparam int unsigned NUM_OPTIONS = 27;
	localparam logic [4:0]  DDASH_INDEX = 5'd26;

	// Token kinds
	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_COMMAND = 2'd1,
		KIND_VALUE   = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	// Line status
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_PARSE = 2'd1,
		STATUS_DUP   = 2'd2
	} status_t;

	// Parser phase, one-hot
	typedef enum logic [10:0] {
		PH_CMD_EMPTY = 11'b000_0000_0001,
		PH_CMD       = 11'b000_0000_0010,
		PH_NORMAL    = 11'b000_0000_0100,
		PH_OPT       = 11'b000_0000_1000,
		PH_SEP       = 11'b000_0001_0000,
		PH_VFIRST    = 11'b000_0010_0000,
		PH_VAL       = 11'b000_0100_0000,
		PH_QUOTED    = 11'b000_1000_0000,
		PH_ESC       = 11'b001_0000_0000,
		PH_SKIP      = 11'b010_0000_0000,
		PH_ERROR     = 11'b100_0000_0000
	} phase_t;

	// Parser state carried from byte to byte
	typedef struct packed {
		phase_t                   phase;
		logic [4:0]               current_option;
		logic [NUM_OPTIONS-1:0]   options_seen;
	} parse_state_t;

	// One result item
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [4:0] option_index;
		logic       in_quotes;
		logic       after_backslash;
		logic       line_done;
		status_t    status;
	} result_t;

endpackage
`default_nettype wire

FILE: design/ctk_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctk_in_if / ctk_out_if: valid/ready channels of the tokenizer
// The input channel moves one line byte per item, the output channel one
// token result per item.
// ----------------------------------------------------------------------------
interface ctk_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;

	modport source (output valid, output line_byte, input ready);
	modport sink   (input valid, input line_byte, output ready);
endinterface

interface ctk_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [4:0] option_index;
	logic       in_quotes;
	logic       after_backslash;
	logic       line_done;
	logic [1:0] status;

	modport source (
		output valid, output kind, output data_byte, output option_index,
		output in_quotes, output after_backslash, output line_done, output status,
		input ready
	);
	modport sink (
		input valid, input kind, input data_byte, input option_index,
		input in_quotes, input after_backslash, input line_done, input status,
		output ready
	);
endinterface
`default_nettype wire

FILE: design/ctk_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctk_step: next-state and result logic for one line byte
// Pure combinational transition of the dash / letter / space / value grammar,
// including quoting, escapes, the double dash option and duplicate detection.
// ----------------------------------------------------------------------------
module ctk_step (
	input  wire logic [7:0]           line_byte,
	input  wire ctk_pkg::parse_state_t cur,
	output ctk_pkg::parse_state_t     nxt,
	output ctk_pkg::result_t          res
);

	logic                            is_dd;
	logic                            is_letter;
	logic [4:0]                      opt_idx;
	logic [ctk_pkg::NUM_OPTIONS-1:0] opt_bit;
	logic                            dup;
	ctk_pkg::parse_state_t           upd;

	assign is_dd     = (cur.current_option == ctk_pkg::DDASH_INDEX);
	assign is_letter = (line_byte >= ctk_pkg::CH_LOWA) &&
	                   (line_byte < ctk_pkg::CH_LOWA + ctk_pkg::NUM_LETTERS);

	// Mask bit of the current option, clamped to the double dash slot
	assign opt_idx = (cur.current_option > ctk_pkg::DDASH_INDEX) ?
	                 ctk_pkg::DDASH_INDEX : cur.current_option;
	assign opt_bit = ctk_pkg::NUM_OPTIONS'(1) << opt_idx;
	assign dup     = cur.options_seen[opt_idx];

	always_comb begin
		upd = cur;
		res = '0;

		unique case (cur.phase)
			ctk_pkg::PH_CMD_EMPTY, ctk_pkg::PH_CMD: begin
				if (line_byte == ctk_pkg::CH_NUL) begin
					res.line_done = 1'b1;
					res.status = (cur.phase == ctk_pkg::PH_CMD_EMPTY) ?
					             ctk_pkg::STATUS_PARSE : ctk_pkg::STATUS_OK;
				end else if (line_byte == ctk_pkg::CH_SPACE) begin
					upd.phase = ctk_pkg::PH_NORMAL;
				end else begin
					res.kind = ctk_pkg::KIND_COMMAND;
					res.data_byte = line_byte;
					upd.phase = ctk_pkg::PH_CMD;
				end
			end
			ctk_pkg::PH_NORMAL: begin
				if (line_byte == ctk_pkg::CH_DASH) begin
					upd.phase = ctk_pkg::PH_OPT;
				end else begin
					res.line_done = 1'b1;
					res.status = ctk_pkg::STATUS_PARSE;
				end
			end
			ctk_pkg::PH_OPT: begin
				if (is_letter) begin
					upd.current_option = 5'(line_byte - ctk_pkg::CH_LOWA);
					upd.phase = ctk_pkg::PH_SEP;
				end else if (line_byte == ctk_pkg::CH_DASH) begin
					upd.current_option = ctk_pkg::DDASH_INDEX;
					upd.phase = ctk_pkg::PH_SEP;
				end else begin
					res.line_done = 1'b1;
					res.status = ctk_pkg::STATUS_PARSE;
				end
			end
			ctk_pkg::PH_SEP: begin
				if (line_byte == ctk_pkg::CH_SPACE) begin
					upd.phase = ctk_pkg::PH_VFIRST;
				end else begin
					res.line_done = 1'b1;
					res.status = ctk_pkg::STATUS_PARSE;
				end
			end
			ctk_pkg::PH_VFIRST: begin
				if (line_byte == ctk_pkg::CH_NUL) begin
					res.line_done = 1'b1;
				end else if (line_byte == ctk_pkg::CH_QUOTE && !is_dd) begin
					upd.phase = ctk_pkg::PH_QUOTED;
				end else begin
					res.kind = ctk_pkg::KIND_VALUE;
					res.data_byte = line_byte;
					upd.phase = ctk_pkg::PH_VAL;
				end
			end
			ctk_pkg::PH_VAL: begin
				// plain value ends at a space, double dash value only at NUL
				if ((line_byte == ctk_pkg::CH_SPACE && !is_dd) ||
				    line_byte == ctk_pkg::CH_NUL) begin
					if (dup) begin
						res.line_done = 1'b1;
						res.status = ctk_pkg::STATUS_DUP;
					end else begin
						upd.options_seen = cur.options_seen | opt_bit;
						res.kind = ctk_pkg::KIND_END;
						upd.phase = ctk_pkg::PH_NORMAL;
						res.line_done = (line_byte == ctk_pkg::CH_NUL);
					end
				end else begin
					res.kind = ctk_pkg::KIND_VALUE;
					res.data_byte = line_byte;
				end
			end
			ctk_pkg::PH_QUOTED: begin
				if (line_byte == ctk_pkg::CH_NUL) begin
					res.line_done = 1'b1;
				end else if (line_byte == ctk_pkg::CH_BSLASH) begin
					res.kind = ctk_pkg::KIND_VALUE;
					res.data_byte = line_byte;
					res.in_quotes = 1'b1;
					upd.phase = ctk_pkg::PH_ESC;
				end else if (line_byte == ctk_pkg::CH_QUOTE) begin
					if (dup) begin
						res.line_done = 1'b1;
						res.status = ctk_pkg::STATUS_DUP;
					end else begin
						upd.options_seen = cur.options_seen | opt_bit;
						res.kind = ctk_pkg::KIND_END;
						upd.phase = ctk_pkg::PH_SKIP;
					end
				end else begin
					res.kind = ctk_pkg::KIND_VALUE;
					res.data_byte = line_byte;
					res.in_quotes = 1'b1;
				end
			end
			ctk_pkg::PH_ESC: begin
				if (line_byte == ctk_pkg::CH_NUL) begin
					res.line_done = 1'b1;
				end else begin
					res.kind = ctk_pkg::KIND_VALUE;
					res.data_byte = line_byte;
					res.in_quotes = 1'b1;
					res.after_backslash = 1'b1;
					upd.phase = ctk_pkg::PH_QUOTED;
				end
			end
			ctk_pkg::PH_SKIP: begin
				if (line_byte == ctk_pkg::CH_NUL) begin
					res.line_done = 1'b1;
				end else begin
					upd.phase = ctk_pkg::PH_NORMAL;
				end
			end
			default: begin
				// error: drop bytes until the line ends
			end
		endcase

		if (res.status != ctk_pkg::STATUS_OK) begin
			upd.phase = ctk_pkg::PH_ERROR;
		end
		res.option_index = upd.current_option;

		// NUL closes the line and starts over
		nxt = upd;
		if (line_byte == ctk_pkg::CH_NUL) begin
			nxt.phase = ctk_pkg::PH_CMD_EMPTY;
			nxt.current_option = '0;
			nxt.options_seen = '0;
		end
	end

endmodule
`default_nettype wire

FILE: design/debugger_command_line_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// debugger_command_line_tokenizer: streaming command line tokenizer
// Splits a NUL-terminated command line into command and option value bytes.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the output does not stall and returns one
// result per byte: the byte lands in an input register, and the grammar
// step, a loop through the phase, current option and 27-bit option mask,
// writes the result register. A stalled output holds the result register
// and a full input register; with no stall both stages move every
// cycle. Each line ends with a byte of 0, which also returns the parser to
// its start state; after a parse error or duplicate option the bytes up to
// that 0 give empty results. Quoted value bytes are passed on raw with
// in_quotes and after_backslash flags for later unescaping.
// ----------------------------------------------------------------------------
module debugger_command_line_tokenizer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ctk_in_if.sink     cmd_line,
	ctk_out_if.source  tokens
);

	logic                  valid_s1;
	logic [7:0]            line_byte_s1;
	logic                  valid_s2;
	ctk_pkg::result_t      res_s2;
	ctk_pkg::parse_state_t state_q;
	ctk_pkg::parse_state_t state_nxt;
	ctk_pkg::result_t      res_nxt;
	logic                  advance;

	// Stage 2 takes a new item when empty or when its result is taken
	assign advance        = !valid_s2 || tokens.ready;
	assign cmd_line.ready = !valid_s1 || advance;

	ctk_step u_step (
		.line_byte (line_byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_line.ready) begin
			valid_s1 <= cmd_line.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_line.ready && cmd_line.valid) begin
			line_byte_s1 <= cmd_line.line_byte;
		end
	end

	// Parser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q.phase <= ctk_pkg::PH_CMD_EMPTY;
			state_q.current_option <= '0;
			state_q.options_seen <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	// Output channel
	assign tokens.valid           = valid_s2;
	assign tokens.kind            = res_s2.kind;
	assign tokens.data_byte       = res_s2.data_byte;
	assign tokens.option_index    = res_s2.option_index;
	assign tokens.in_quotes       = res_s2.in_quotes;
	assign tokens.after_backslash = res_s2.after_backslash;
	assign tokens.line_done       = res_s2.line_done;
	assign tokens.status          = res_s2.status;

endmodule
`default_nettype wire

FILE: design/ctk_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctk_checker: port-level checks of the command line tokenizer
// Watches the result channel for consistent flags and a held stalled item.
// ----------------------------------------------------------------------------
module ctk_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] data_byte,
	input wire logic       in_quotes,
	input wire logic       after_backslash,
	input wire logic       line_done,
	input wire logic [1:0] status
);

	// A stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
		&& $stable(status) && $stable(line_done))
		else $error("stalled result item changed");

	// Status is only reported on the byte that ends the line
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_done |-> status == ctk_pkg::STATUS_OK)
		else $error("status without line_done");

	// Only command and value bytes carry data
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == ctk_pkg::KIND_NONE || kind == ctk_pkg::KIND_END)
		|-> data_byte == 8'd0)
		else $error("data on a non-data item");

	// Escape flag implies a quoted value byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && after_backslash |-> in_quotes && kind == ctk_pkg::KIND_VALUE)
		else $error("after_backslash outside a quoted value");

	// Quote flag only on value bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_quotes |-> kind == ctk_pkg::KIND_VALUE)
		else $error("in_quotes on a non-value item");

endmodule

bind debugger_command_line_tokenizer ctk_checker u_ctk_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (tokens.valid),
	.out_ready       (tokens.ready),
	.kind            (tokens.kind),
	.data_byte       (tokens.data_byte),
	.in_quotes       (tokens.in_quotes),
	.after_backslash (tokens.after_backslash),
	.line_done       (tokens.line_done),
	.status          (tokens.status)
);
`default_nettype wire
